FILE: src/sobel_edge_magnitude_core_macros.svh
// Assertion macros shared by the Sobel edge magnitude core.
`ifndef SOBEL_EDGE_MAGNITUDE_CORE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_CORE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SEM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sobel core check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SEM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sobel core check failed");

`endif

FILE: src/sem_pkg.sv
// Types, constants and kernel tables of the Sobel edge magnitude core.
package sem_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_RADIUS = 3;
  localparam int HEIGHT_CAP     = 4096;
  localparam int ROW_BITS       = 13;
  localparam int CFG_BITS       = 13;
  localparam int HD_BITS        = 16;
  localparam int GX_BITS        = 21;
  localparam int MAG_BITS       = 19;
  localparam int SQ_BITS        = 38;
  localparam int ROOT_TOP       = 36;

  localparam logic [1:0] CFG_WIDTH     = 2'd0;
  localparam logic [1:0] CFG_HEIGHT    = 2'd1;
  localparam logic [1:0] CFG_RADIUS    = 2'd2;
  localparam logic [1:0] CFG_DIRECTION = 2'd3;

  localparam logic [1:0] DIR_X = 2'd0;
  localparam logic [1:0] DIR_Y = 2'd1;

  localparam logic signed [5:0] DERIV_TAB [3][7] = '{
    '{-6'sd1, 6'sd0, 6'sd1, 6'sd0, 6'sd0, 6'sd0, 6'sd0},
    '{-6'sd1, -6'sd2, 6'sd0, 6'sd2, 6'sd1, 6'sd0, 6'sd0},
    '{-6'sd1, -6'sd4, -6'sd5, 6'sd0, 6'sd5, 6'sd4, 6'sd1}
  };

  localparam logic [4:0] SMOOTH_TAB [3][7] = '{
    '{5'd1, 5'd2, 5'd1, 5'd0, 5'd0, 5'd0, 5'd0},
    '{5'd1, 5'd4, 5'd6, 5'd4, 5'd1, 5'd0, 5'd0},
    '{5'd1, 5'd6, 5'd15, 5'd20, 5'd15, 5'd6, 5'd1}
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_ACC,
    ST_ROW,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_FIN
  } state_t;

endpackage

FILE: src/sobel_edge_magnitude_core.sv
// Sobel edge magnitude core: line store, tap sequencer and square root unit.
// For an item that completes an output, the sequencer does one memory read and one
// accumulate per kernel tap and one row sum per row, then goes to the finish state for
// X or Y only, or squares both sums and runs 19 square root steps for the magnitude.
// The core takes one item at a time: in_stall is low only in idle, so a new item waits.
// Reset clears the position counters and out_valid and loads width 1024, height 1024, radius 1, direction 2.
`include "sobel_edge_magnitude_core_macros.svh"
module sobel_edge_magnitude_core
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                mode,
  input  logic [7:0]          pixel,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          edge_res,
  output logic                frame_end
);

  localparam int SLOTS = 2 * MAX_RADIUS + 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = CW + 1;
  localparam int SW    = $clog2(SLOTS);
  localparam int AW    = $clog2(SLOTS * MAX_WIDTH);

  state_t state, state_next;

  logic [10:0]         image_width;
  logic [12:0]         image_height;
  logic [1:0]          kernel_radius;
  logic [1:0]          direction;

  logic [CW-1:0]       in_column;
  logic [ROW_BITS-1:0] in_row;
  logic [SW-1:0]       in_slot;
  logic [CW-1:0]       out_column;
  logic [ROW_BITS-1:0] out_row;
  logic [SW-1:0]       out_slot;

  logic [7:0]          row_store [SLOTS*MAX_WIDTH];
  logic [7:0]          rdata;

  logic [2:0]                ki, ji;
  logic signed [HD_BITS-1:0] hd;
  logic [HD_BITS-1:0]        hs;
  logic signed [GX_BITS-1:0] gx, gy;
  logic [SQ_BITS-1:0]        sumsq, sq_res, sq_bit;
  logic [MAG_BITS-1:0]       mag;

  logic [WW-1:0]       eff_w;
  logic [ROW_BITS-1:0] eff_h;
  logic [1:0]          eff_r;
  logic [1:0]          tab_row;
  logic [2:0]          two_r;
  logic                in_take, input_done, take_pixel, ready, last, fin_go;
  logic [AW-1:0]       waddr, raddr;
  logic signed [HD_BITS-1:0] prod_d;
  logic [HD_BITS-1:0]        prod_s;
  logic signed [GX_BITS-1:0] row_x, row_y;
  logic [MAG_BITS-1:0]       abs_x, abs_y, shifted;
  logic [SQ_BITS-1:0]        trial, res_step;
  logic [7:0]                edge_sat;

  always_comb begin
    if (image_width == '0) begin
      eff_w = WW'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width);
    end
    if (image_height == '0) begin
      eff_h = ROW_BITS'(1);
    end else if (int'(image_height) > HEIGHT_CAP) begin
      eff_h = ROW_BITS'(HEIGHT_CAP);
    end else begin
      eff_h = image_height;
    end
    if (kernel_radius == '0) begin
      eff_r = 2'd1;
    end else if (int'(kernel_radius) > MAX_RADIUS) begin
      eff_r = 2'(MAX_RADIUS);
    end else begin
      eff_r = kernel_radius;
    end
  end

  assign tab_row    = eff_r - 2'd1;
  assign two_r      = {eff_r, 1'b0};
  assign in_take    = in_valid && !in_stall;
  assign input_done = int'(in_row) >= int'(eff_h);
  assign take_pixel = in_take && !mode && !input_done;
  assign waddr      = AW'(int'(in_slot) * MAX_WIDTH + int'(in_column));
  assign last       = (int'(out_column) == int'(eff_w) - 1) &&
                      (int'(out_row) == int'(eff_h) - 1);
  assign fin_go     = (state == ST_FIN) && (!out_valid || !out_stall);

  always_comb begin
    int need_row, need_col;
    need_row = int'(out_row) + int'(eff_r);
    if (need_row > int'(eff_h) - 1) begin
      need_row = int'(eff_h) - 1;
    end
    need_col = int'(out_column) + int'(eff_r);
    if (need_col > int'(eff_w) - 1) begin
      need_col = int'(eff_w) - 1;
    end
    ready = input_done || (int'(in_row) > need_row) ||
            ((int'(in_row) == need_row) && (int'(in_column) > need_col));
  end

  always_comb begin
    int col, prow, slot;
    col = int'(out_column) + int'(ji) - int'(eff_r);
    if (col < 0) begin
      col = 0;
    end else if (col > int'(eff_w) - 1) begin
      col = int'(eff_w) - 1;
    end
    prow = int'(out_row) + int'(ki) - int'(eff_r);
    if (prow < 0) begin
      prow = 0;
    end else if (prow > int'(eff_h) - 1) begin
      prow = int'(eff_h) - 1;
    end
    slot = int'(out_slot) + prow - int'(out_row);
    if (slot < 0) begin
      slot = slot + SLOTS;
    end else if (slot >= SLOTS) begin
      slot = slot - SLOTS;
    end
    raddr = AW'(slot * MAX_WIDTH + col);
  end

  assign prod_d   = $signed({1'b0, rdata}) * DERIV_TAB[tab_row][ji];
  assign prod_s   = rdata * SMOOTH_TAB[tab_row][ji];
  assign row_x    = hd * $signed({1'b0, SMOOTH_TAB[tab_row][ki]});
  assign row_y    = $signed({1'b0, hs}) * DERIV_TAB[tab_row][ki];
  assign abs_x    = MAG_BITS'(gx[GX_BITS-1] ? -gx : gx);
  assign abs_y    = MAG_BITS'(gy[GX_BITS-1] ? -gy : gy);
  assign trial    = sq_res + sq_bit;
  assign res_step = (sumsq >= trial) ? ((sq_res >> 1) + sq_bit) : (sq_res >> 1);
  assign shifted  = mag >> two_r;
  assign edge_sat = (|shifted[MAG_BITS-1:8]) ? 8'hFF : shifted[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: state_next = ready ? ST_READ : ST_IDLE;
      ST_READ:  state_next = ST_ACC;
      ST_ACC:   state_next = (ji == two_r) ? ST_ROW : ST_READ;
      ST_ROW:   state_next = (ki == two_r) ? ST_SQX : ST_READ;
      ST_SQX:   state_next = (direction == DIR_X || direction == DIR_Y) ? ST_FIN : ST_SQY;
      ST_SQY:   state_next = ST_ROOT;
      ST_ROOT:  state_next = sq_bit[0] ? ST_FIN : ST_ROOT;
      ST_FIN: begin
        if (fin_go) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take_pixel) begin
      row_store[waddr] <= pixel;
    end
    if (state == ST_READ) begin
      rdata <= row_store[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 11'd1024;
      image_height  <= 13'd1024;
      kernel_radius <= 2'd1;
      direction     <= 2'd2;
      in_column     <= '0;
      in_row        <= '0;
      in_slot       <= '0;
      out_column    <= '0;
      out_row       <= '0;
      out_slot      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WIDTH:     image_width   <= cfg_data[10:0];
          CFG_HEIGHT:    image_height  <= cfg_data[12:0];
          CFG_RADIUS:    kernel_radius <= cfg_data[1:0];
          CFG_DIRECTION: direction     <= cfg_data[1:0];
          default:       direction     <= direction;
        endcase
        in_column  <= '0;
        in_row     <= '0;
        in_slot    <= '0;
        out_column <= '0;
        out_row    <= '0;
        out_slot   <= '0;
      end else begin
        if (take_pixel) begin
          if (int'(in_column) + 1 >= int'(eff_w)) begin
            in_column <= '0;
            in_row    <= in_row + 1'b1;
            in_slot   <= (in_slot == SW'(SLOTS - 1)) ? '0 : in_slot + 1'b1;
          end else begin
            in_column <= in_column + 1'b1;
          end
        end
        if (fin_go) begin
          out_valid <= 1'b1;
          if (last) begin
            in_column  <= '0;
            in_row     <= '0;
            in_slot    <= '0;
            out_column <= '0;
            out_row    <= '0;
            out_slot   <= '0;
          end else if (int'(out_column) + 1 >= int'(eff_w)) begin
            out_column <= '0;
            out_row    <= out_row + 1'b1;
            out_slot   <= (out_slot == SW'(SLOTS - 1)) ? '0 : out_slot + 1'b1;
          end else begin
            out_column <= out_column + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_CHECK: begin
        ki <= '0;
        ji <= '0;
        hd <= '0;
        hs <= '0;
        gx <= '0;
        gy <= '0;
      end
      ST_ACC: begin
        hd <= hd + prod_d;
        hs <= hs + prod_s;
        ji <= ji + 1'b1;
      end
      ST_ROW: begin
        gx <= gx + row_x;
        gy <= gy + row_y;
        hd <= '0;
        hs <= '0;
        ji <= '0;
        ki <= ki + 1'b1;
      end
      ST_SQX: begin
        if (direction == DIR_X) begin
          mag <= abs_x;
        end else if (direction == DIR_Y) begin
          mag <= abs_y;
        end else begin
          sumsq <= SQ_BITS'(abs_x * abs_x);
        end
      end
      ST_SQY: begin
        sumsq  <= sumsq + SQ_BITS'(abs_y * abs_y);
        sq_res <= '0;
        sq_bit <= SQ_BITS'(1) << ROOT_TOP;
      end
      ST_ROOT: begin
        if (sumsq >= trial) begin
          sumsq <= sumsq - trial;
        end
        sq_res <= res_step;
        sq_bit <= sq_bit >> 2;
        if (sq_bit[0]) begin
          mag <= res_step[MAG_BITS-1:0];
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          edge_res  <= edge_sat;
          frame_end <= last;
        end
      end
      default: begin
      end
    endcase
  end

  `SEM_ASSERT_NEXT(a_busy_after_take, clk, rst, in_take && !cfg_we, in_stall)
  `SEM_ASSERT_NEXT(a_frame_restart, clk, rst, fin_go && last && !cfg_we, out_row == '0 && out_column == '0 && in_row == '0)
  `SEM_ASSERT_NOW(a_input_bounded, clk, rst, state == ST_CHECK, int'(in_row) <= int'(eff_h))

endmodule

FILE: test/sobel_edge_magnitude_core_test.sv
// Testbench for the Sobel edge magnitude core: predicts each edge word and checks it.
module sobel_edge_magnitude_core_test;
  import sem_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_WIDTH = 1024;
  localparam int LINE_ROWS = 7;
  localparam int SETTLE_CYCLES = 300;
  localparam int STALL_LIMIT = 20000;

  localparam int DERIV_K[3][7] = '{
    '{-1, 0, 1, 0, 0, 0, 0},
    '{-1, -2, 0, 2, 1, 0, 0},
    '{-1, -4, -5, 0, 5, 4, 1}
  };
  localparam int SMOOTH_K[3][7] = '{
    '{1, 2, 1, 0, 0, 0, 0},
    '{1, 4, 6, 4, 1, 0, 0},
    '{1, 6, 15, 20, 15, 6, 1}
  };

  typedef struct packed {
    logic [7:0] edge_val;
    logic       last;
  } edge_word_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = CFG_WIDTH;
  logic [CFG_BITS-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                mode = 1'b0;
  logic [7:0]          pixel = 8'd0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          edge_res;
  logic                frame_end;

  sobel_edge_magnitude_core u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .pixel(pixel),
    .out_valid(out_valid), .out_stall(out_stall), .edge_res(edge_res),
    .frame_end(frame_end)
  );

  always #5 clk = ~clk;

  edge_word_t pending_edges[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int pixels_sent = 0;
  int quiet_cycles = 0;

  logic [7:0] line_buf[LINE_ROWS * LINE_WIDTH];
  int wr_col, wr_row, rd_col, rd_row;
  int reg_width, reg_height, reg_radius, reg_dir;

  function automatic int clamp_int(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int used_width();
    return reg_width == 0 ? 1 : (reg_width > LINE_WIDTH ? LINE_WIDTH : reg_width);
  endfunction

  function automatic int used_height();
    return reg_height == 0 ? 1 : (reg_height > HEIGHT_CAP ? HEIGHT_CAP : reg_height);
  endfunction

  function automatic int used_radius();
    return reg_radius == 0 ? 1 : reg_radius;
  endfunction

  function automatic void restart_positions();
    wr_col = 0;
    wr_row = 0;
    rd_col = 0;
    rd_row = 0;
  endfunction

  function automatic bit frame_idle();
    return wr_col == 0 && wr_row == 0 && rd_col == 0 && rd_row == 0;
  endfunction

  function automatic logic [7:0] edge_at(int ox, int oy, int w, int h, int r);
    longint gx, gy, hd, hs, p, py;
    longint unsigned v, root, bt;
    gx = 0;
    gy = 0;
    for (int k = -r; k <= r; k++) begin
      py = clamp_int(oy + k, 0, h - 1);
      hd = 0;
      hs = 0;
      for (int j = -r; j <= r; j++) begin
        p = line_buf[(py % LINE_ROWS) * LINE_WIDTH + clamp_int(ox + j, 0, w - 1)];
        hd += p * DERIV_K[r-1][j+r];
        hs += p * SMOOTH_K[r-1][j+r];
      end
      gx += hd * SMOOTH_K[r-1][k+r];
      gy += hs * DERIV_K[r-1][k+r];
    end
    if (gx < 0) gx = -gx;
    if (gy < 0) gy = -gy;
    if (reg_dir == DIR_X) begin
      v = gx;
    end else if (reg_dir == DIR_Y) begin
      v = gy;
    end else begin
      v = gx * gx + gy * gy;
      root = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt >>= 2;
      while (bt != 0) begin
        if (v >= root + bt) begin
          v -= root + bt;
          root = (root >> 1) + bt;
        end else begin
          root >>= 1;
        end
        bt >>= 2;
      end
      v = root;
    end
    v >>= 2 * r;
    return v > 255 ? 8'd255 : v[7:0];
  endfunction

  function automatic bit advance_sobel(bit m, logic [7:0] p, output edge_word_t res);
    int w, h, r, need_row, need_col;
    bit input_done;
    w = used_width();
    h = used_height();
    r = used_radius();
    if (wr_row > h) wr_row = h;
    if (wr_col >= w) wr_col = 0;
    if (rd_row >= h || rd_col >= w) restart_positions();
    input_done = wr_row >= h;
    if (!m && !input_done) begin
      line_buf[(wr_row % LINE_ROWS) * LINE_WIDTH + wr_col] = p;
      wr_col++;
      if (wr_col >= w) begin
        wr_col = 0;
        wr_row++;
      end
      input_done = wr_row >= h;
    end
    need_row = rd_row + r > h - 1 ? h - 1 : rd_row + r;
    need_col = rd_col + r > w - 1 ? w - 1 : rd_col + r;
    if (!input_done && !(wr_row > need_row || (wr_row == need_row && wr_col > need_col)))
      return 1'b0;
    res.edge_val = edge_at(rd_col, rd_row, w, h, r);
    res.last = rd_col == w - 1 && rd_row == h - 1;
    if (res.last) begin
      restart_positions();
    end else begin
      rd_col++;
      if (rd_col >= w) begin
        rd_col = 0;
        rd_row++;
      end
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    edge_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_edges.size() == 0) begin
        report_mismatch("unexpected word", edge_res, -1);
      end else begin
        want = pending_edges.pop_front();
        if (edge_res !== want.edge_val) report_mismatch("edge_res", edge_res, want.edge_val);
        if (frame_end !== want.last) report_mismatch("frame_end", frame_end, want.last);
      end
    end
    if (hold_left > 0) hold_left--;
    out_stall <= hold_left > 0 || $urandom_range(99) < recv_stall_pct;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(bit m, logic [7:0] p);
    edge_word_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    pixel <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!m) pixels_sent++;
    if (advance_sobel(m, p, res)) pending_edges.push_back(res);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_BITS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WIDTH: reg_width = value & 'h7FF;
      CFG_HEIGHT: reg_height = value & 'h1FFF;
      CFG_RADIUS: reg_radius = value & 3;
      default: reg_dir = value & 3;
    endcase
    restart_positions();
  endtask

  task automatic set_geometry(int w, int h, int r, int d);
    settle();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_RADIUS, r);
    write_reg(CFG_DIRECTION, d);
  endtask

  function automatic logic [7:0] pick_pixel();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  // Sends npix pixels with drain noise; if finish_it is set, the frame is then run to its end with mostly drain words.
  task automatic push_frame(int npix, int noise, bit finish_it);
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(99) < noise) send_word(1'b1, 8'($urandom));
      send_word(1'b0, pick_pixel());
    end
    if (finish_it) begin
      while (!frame_idle()) send_word($urandom_range(9) != 0, 8'($urandom));
    end
  endtask

  task automatic test_directed();
    set_geometry(7, 7, 3, 2);
    for (int i = 0; i < 12; i++) send_word(1'b0, i[0] ? 8'hFF : 8'h00);
    send_word(1'b1, 8'hA5);
    send_word(1'b0, 8'h5A);
    push_frame(35, 0, 1'b0);
    send_word(1'b0, 8'h81);
    while (!frame_idle()) send_word(1'b1, 8'h00);
    set_geometry(0, 0, 0, 3);
    push_frame(1, 0, 1'b1);
    set_geometry(3, 2, 2, 0);
    push_frame(6, 20, 1'b1);
    set_geometry(8, 9, 1, 1);
    push_frame(72, 10, 1'b1);
  endtask

  task automatic test_register_extremes();
    set_geometry(2047, 1, 3, 2);
    push_frame(40, 0, 1'b0);
    set_geometry(1, 8191, 1, 0);
    push_frame(40, 0, 1'b0);
    set_geometry(5, 4, 2, 1);
    push_frame(7, 0, 1'b0);
  endtask

  task automatic test_backpressure();
    set_geometry(12, 8, 1, 2);
    hold_left = 600;
    push_frame(96, 0, 1'b1);
  endtask

  task automatic test_random(int idle_pct, int stall_pct, int count);
    int w, h, goal;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    goal = pixels_sent + count;
    while (pixels_sent < goal) begin
      w = $urandom_range(9) == 0 ? $urandom_range(60, 13) : $urandom_range(12, 1);
      h = $urandom_range(10, 1);
      set_geometry(w, h, $urandom_range(3), $urandom_range(3));
      if ($urandom_range(9) == 0)
        push_frame($urandom_range(w * h - 1), 8, 1'b0);
      else
        push_frame(w * h, 8, 1'b1);
    end
  endtask

  initial begin
    foreach (line_buf[i]) line_buf[i] = 8'd0;
    restart_positions();
    reg_width = 1024;
    reg_height = 1024;
    reg_radius = 1;
    reg_dir = 2;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random(0, 0, 200);
    test_random(57, 0, 200);
    test_random(0, 57, 200);
    test_random(20, 20, 200);
    settle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+src
src/sem_pkg.sv
src/sobel_edge_magnitude_core.sv
test/sobel_edge_magnitude_core_test.sv
